### rtl/fisq_pkg.sv
// Package: binary32 constants and the rounding multiply and add used by the pipeline.
package fisq_pkg;

	localparam logic [31:0] MAGIC     = 32'h5f3759df;
	localparam logic [31:0] F32_HALF  = 32'h3F000000;
	localparam logic [31:0] F32_1P5   = 32'h3FC00000;
	localparam logic [31:0] CANON_NAN = 32'h7FC00000;
	localparam logic [7:0]  EXP_MAX   = 8'hFF;

	function automatic logic is_nan(logic [31:0] a);
		return (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(logic [31:0] a);
		return (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
	endfunction

	// Leading zeros of a 48-bit word (48 when all zero)
	function automatic logic [5:0] lzc48(logic [47:0] v);
		logic [5:0] n;
		logic       hit;
		n   = 6'd48;
		hit = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 6'(47 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// Leading zeros of a 27-bit word (27 when all zero)
	function automatic logic [4:0] lzc27(logic [26:0] v);
		logic [4:0] n;
		logic       hit;
		n   = 5'd27;
		hit = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 5'(26 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// binary32 multiply, round to nearest even, gradual underflow
	function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
		logic               s;
		logic [7:0]         ea, eb;
		logic [23:0]        ma, mb;
		logic [47:0]        p, m;
		logic [5:0]         lz;
		logic signed [10:0] er, d;
		logic [6:0]         sh;
		logic [95:0]        w;
		logic               sticky0, guard, sticky, inc;
		logic [30:0]        pk;
		logic [31:0]        r;
		s  = a[31] ^ b[31];
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		p  = ma * mb;
		lz = lzc48(p);
		m  = p << lz;
		er = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126 - $signed({5'b0, lz});
		sticky0 = 1'b0;
		// underflow: denormalize with sticky collection
		if (er < 11'sd1) begin
			d  = 11'sd1 - er;
			sh = (d > 11'sd63) ? 7'd63 : d[6:0];
			w  = {m, 48'd0} >> sh;
			m  = w[95:48];
			sticky0 = |w[47:0];
			er = 11'sd0;
		end
		guard  = m[23];
		sticky = (|m[22:0]) | sticky0;
		inc    = guard & (sticky | m[24]);
		pk     = {er[7:0], m[46:24]} + {30'd0, inc};
		r      = {s, pk};
		if (er >= 11'sd255)
			r = {s, EXP_MAX, 23'd0};
		// specials
		if (is_nan(a) || is_nan(b))
			r = CANON_NAN;
		else if (is_inf(a) || is_inf(b)) begin
			if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
				r = CANON_NAN;
			else
				r = {s, EXP_MAX, 23'd0};
		end else if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
			r = {s, 31'd0};
		return r;
	endfunction

	// binary32 add, round to nearest even, gradual underflow
	function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
		logic [31:0] x, y, r;
		logic        sub, s;
		logic [8:0]  e;
		logic [7:0]  ey, dd;
		logic [4:0]  dsh, lz, lsh;
		logic [26:0] amag, bs;
		logic [53:0] w;
		logic [27:0] sum;
		logic [26:0] n;
		logic        guard, sticky, inc;
		logic [7:0]  fld;
		logic [30:0] pk;
		// larger magnitude first
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		sub  = x[31] ^ y[31];
		e    = (x[30:23] == 8'd0) ? 9'd1 : {1'b0, x[30:23]};
		ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		dd   = e[7:0] - ey;
		dsh  = (dd > 8'd31) ? 5'd31 : dd[4:0];
		amag = {(x[30:23] != 8'd0), x[22:0], 3'b000};
		// align smaller operand, keep sticky in lsb
		w    = {(y[30:23] != 8'd0), y[22:0], 3'b000, 27'd0} >> dsh;
		bs   = {w[53:28], w[27] | (|w[26:0])};
		sum  = sub ? ({1'b0, amag} - {1'b0, bs}) : ({1'b0, amag} + {1'b0, bs});
		// normalize
		if (sum[27]) begin
			n = {sum[27:2], sum[1] | sum[0]};
			e = e + 9'd1;
		end else begin
			lz  = lzc27(sum[26:0]);
			lsh = ({4'd0, lz} > (e - 9'd1)) ? 5'((e - 9'd1)) : lz;
			n   = sum[26:0] << lsh;
			e   = e - {4'd0, lsh};
		end
		fld    = n[26] ? e[7:0] : 8'd0;
		guard  = n[2];
		sticky = n[1] | n[0];
		inc    = guard & (sticky | n[3]);
		pk     = {fld, n[25:3]} + {30'd0, inc};
		s      = x[31];
		if (sum == 28'd0)
			s = sub ? 1'b0 : x[31];
		r = {s, pk};
		if (e >= 9'd255)
			r = {s, EXP_MAX, 23'd0};
		// specials
		if (is_nan(a) || is_nan(b))
			r = CANON_NAN;
		else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
			r = CANON_NAN;
		else if (is_inf(a))
			r = a;
		else if (is_inf(b))
			r = b;
		return r;
	endfunction

endpackage

### rtl/fisq_if.sv
// Interfaces: input and result channels with valid/ready handshake.
interface fisq_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] x_bits;
	modport source (output valid, output x_bits, input ready);
	modport sink   (input valid, input x_bits, output ready);
endinterface

interface fisq_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] y_bits;
	modport source (output valid, output y_bits, input ready);
	modport sink   (input valid, input y_bits, output ready);
endinterface

### rtl/fast_inverse_sqrt_single.sv
// Top level: nine-stage binary32 fast reciprocal square root pipeline.
//
//  channel  dir  payload        handshake
//  x_ch     in   x_bits[31:0]   valid/ready
//  y_ch     out  y_bits[31:0]   valid/ready
//
// One item per cycle while the output is not stalled; one binary32 operation per stage
// (halving and guess, then multiply, multiply, subtract, multiply, twice).
// Reset clears only the stage valid bits.
// A stall holds the whole pipeline: it advances when the last stage is
// empty or its item is taken, so the last stage doubles as output register.
module fast_inverse_sqrt_single (
	input logic clk,
	input logic arst_n,
	fisq_in_if.sink    x_ch,
	fisq_out_if.source y_ch
);

	logic        adv;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        valid_s6, valid_s7, valid_s8, valid_s9;
	logic [31:0] h_s1, h_s2, h_s3, h_s4, h_s5;
	logic [31:0] y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8, y_s9;
	logic [31:0] t_s2, t_s6;
	logic [31:0] u_s3, u_s7;
	logic [31:0] v_s4, v_s8;
	logic [31:0] r_fin;

	assign adv        = !valid_s9 || y_ch.ready;
	assign x_ch.ready = adv;
	assign y_ch.valid = valid_s9;
	assign y_ch.y_bits = y_s9;

	// final product with NaN canonicalized
	always_comb begin
		r_fin = fisq_pkg::fmul(y_s8, v_s8);
		if (fisq_pkg::is_nan(r_fin))
			r_fin = fisq_pkg::CANON_NAN;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= x_ch.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// halve input, bit-level initial guess
			h_s1 <= fisq_pkg::fmul(x_ch.x_bits, fisq_pkg::F32_HALF);
			y_s1 <= fisq_pkg::MAGIC - {1'b0, x_ch.x_bits[31:1]};
			// first Newton step
			t_s2 <= fisq_pkg::fmul(h_s1, y_s1);
			h_s2 <= h_s1;
			y_s2 <= y_s1;
			u_s3 <= fisq_pkg::fmul(t_s2, y_s2);
			h_s3 <= h_s2;
			y_s3 <= y_s2;
			v_s4 <= fisq_pkg::fadd(fisq_pkg::F32_1P5, {~u_s3[31], u_s3[30:0]});
			h_s4 <= h_s3;
			y_s4 <= y_s3;
			y_s5 <= fisq_pkg::fmul(y_s4, v_s4);
			h_s5 <= h_s4;
			// second Newton step
			t_s6 <= fisq_pkg::fmul(h_s5, y_s5);
			y_s6 <= y_s5;
			u_s7 <= fisq_pkg::fmul(t_s6, y_s6);
			y_s7 <= y_s6;
			v_s8 <= fisq_pkg::fadd(fisq_pkg::F32_1P5, {~u_s7[31], u_s7[30:0]});
			y_s8 <= y_s7;
			y_s9 <= r_fin;
		end
	end

endmodule
